// ===== design/bdc_pkg.sv =====
// Shared types and constants for the buoyancy depth controller.
// No dependencies; every other design file imports this package.
package bdc_pkg;

    localparam int P_BITS    = 19;
    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;

    typedef enum logic [2:0] {
        REG_TARGET   = 3'd0,
        REG_START    = 3'd1,
        REG_BAND     = 3'd2,
        REG_PROGRESS = 3'd3,
        REG_SPEED    = 3'd4,
        REG_HOLD     = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        MOT_RISE = 2'd0,
        MOT_SINK = 2'd1,
        MOT_STOP = 2'd2
    } t_motion;

    typedef struct packed {
        logic [P_BITS-1:0] pressure_q4;
        logic [31:0]       now_ms;
        logic              mode_sw;
        logic              push_sw;
        logic              pull_sw;
    } t_in_item;

    typedef struct packed {
        logic [7:0] drive_a;
        logic [7:0] drive_b;
        t_motion    motion;
        logic       auto_active;
        logic       calibrated;
    } t_out_item;

    typedef struct packed {
        logic [P_BITS-1:0] target_pressure_q4;
        logic [P_BITS-1:0] start_pressure_q4;
        logic [11:0]       stop_band_q4;
        logic [11:0]       progress_delta_q4;
        logic [7:0]        drive_speed;
        logic [15:0]       hold_ms;
    } t_cfg;

    localparam logic [P_BITS-1:0] RST_TARGET   = P_BITS'(16880);
    localparam logic [P_BITS-1:0] RST_START    = P_BITS'(16368);
    localparam logic [11:0]       RST_BAND     = 12'd80;
    localparam logic [11:0]       RST_PROGRESS = 12'd16;
    localparam logic [7:0]        RST_SPEED    = 8'd255;
    localparam logic [15:0]       RST_HOLD     = 16'd5000;
    localparam logic [P_BITS-1:0] RST_PREV     = P_BITS'(159984);
    localparam logic [P_BITS-1:0] RST_MIN      = P_BITS'(160000);

    localparam logic [31:0] SETTLE_MS   = 32'd2000;
    localparam logic [31:0] WIN_LO_MS   = 32'd1000;
    localparam logic [31:0] WIN_HI_MS   = 32'd1500;
    localparam logic [31:0] PHASE_MS    = 32'd1800;
    localparam logic [31:0] HALF_MS     = 32'd900;

endpackage

// ===== design/bdc_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on bdc_pkg for the register indexes and the t_cfg struct.
module bdc_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bdc_pkg::ADDR_BITS-1:0] paddr,
    input  logic [bdc_pkg::DATA_BITS-1:0] pwdata,
    output logic [bdc_pkg::DATA_BITS-1:0] prdata,
    output logic                         pready,
    output bdc_pkg::t_cfg                o_cfg
);
    import bdc_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (idx)
                REG_TARGET:   n_cfg.target_pressure_q4 = pwdata[P_BITS-1:0];
                REG_START:    n_cfg.start_pressure_q4  = pwdata[P_BITS-1:0];
                REG_BAND:     n_cfg.stop_band_q4       = pwdata[11:0];
                REG_PROGRESS: n_cfg.progress_delta_q4  = pwdata[11:0];
                REG_SPEED:    n_cfg.drive_speed        = pwdata[7:0];
                REG_HOLD:     n_cfg.hold_ms            = pwdata[15:0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_TARGET:   prdata = DATA_BITS'(r_cfg.target_pressure_q4);
            REG_START:    prdata = DATA_BITS'(r_cfg.start_pressure_q4);
            REG_BAND:     prdata = DATA_BITS'(r_cfg.stop_band_q4);
            REG_PROGRESS: prdata = DATA_BITS'(r_cfg.progress_delta_q4);
            REG_SPEED:    prdata = DATA_BITS'(r_cfg.drive_speed);
            REG_HOLD:     prdata = DATA_BITS'(r_cfg.hold_ms);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_pressure_q4 <= RST_TARGET;
            r_cfg.start_pressure_q4  <= RST_START;
            r_cfg.stop_band_q4       <= RST_BAND;
            r_cfg.progress_delta_q4  <= RST_PROGRESS;
            r_cfg.drive_speed        <= RST_SPEED;
            r_cfg.hold_ms            <= RST_HOLD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== design/bdc_ctrl.sv =====
// Controller state and the one-item update: mode latch, minimum search,
// timed pulsing toward target. Depends on bdc_pkg.
module bdc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bdc_pkg::t_cfg      i_cfg,
    input  logic               i_step,
    input  bdc_pkg::t_in_item  i_item,
    output bdc_pkg::t_out_item o_result
);
    import bdc_pkg::*;

    localparam int W = P_BITS + 2;

    logic              r_auto, r_settled, r_sink_p, r_rise_p;
    logic [P_BITS-1:0] r_prev, r_min;
    logic [31:0]       r_mark;
    logic [7:0]        r_pin_a, r_pin_b;
    t_motion           r_motion;

    logic              n_auto, n_settled, n_sink_p, n_rise_p;
    logic [P_BITS-1:0] n_prev, n_min;
    logic [31:0]       n_mark;
    logic [7:0]        n_pin_a, n_pin_b;
    t_motion           n_motion;

    logic              do_drive;
    t_motion           cmd;
    logic [31:0]       el;
    logic signed [W-1:0] c_s, tgt_s, band_s, dlt_s, min_s, prev_s;
    logic              in_band;

    assign el     = i_item.now_ms - r_mark;
    assign c_s    = $signed({2'b00, i_item.pressure_q4});
    assign tgt_s  = $signed({2'b00, i_cfg.target_pressure_q4});
    assign band_s = $signed({{(W-12){1'b0}}, i_cfg.stop_band_q4});
    assign dlt_s  = $signed({{(W-12){1'b0}}, i_cfg.progress_delta_q4});
    assign min_s  = $signed({2'b00, r_min});
    assign prev_s = $signed({2'b00, r_prev});
    assign in_band = (c_s > tgt_s - band_s) && (c_s < tgt_s + band_s);

    // Decide the command and the flag and timer updates for this item.
    always_comb begin
        n_auto    = r_auto;
        n_settled = r_settled;
        n_sink_p  = r_sink_p;
        n_rise_p  = r_rise_p;
        n_prev    = r_prev;
        n_min     = r_min;
        n_mark    = r_mark;
        do_drive  = 1'b0;
        cmd       = MOT_STOP;
        if (!r_auto) begin
            if (i_item.mode_sw) begin
                n_auto = 1'b1;
            end else if (i_item.push_sw && !i_item.pull_sw) begin
                do_drive = 1'b1;
                cmd      = MOT_SINK;
            end else if (i_item.pull_sw && !i_item.push_sw) begin
                do_drive = 1'b1;
                cmd      = MOT_RISE;
            end else begin
                do_drive = 1'b1;
            end
        end else if (i_item.pressure_q4 < i_cfg.start_pressure_q4) begin
            do_drive = 1'b1;
        end else if (!r_settled) begin
            if (el >= SETTLE_MS) begin
                if (c_s - min_s <= dlt_s) begin
                    n_settled = 1'b1;
                end
                n_mark = i_item.now_ms;
            end else if (el >= WIN_LO_MS && el < WIN_HI_MS) begin
                if (r_min > i_item.pressure_q4) begin
                    n_min = i_item.pressure_q4;
                end
            end
        end else if (in_band) begin
            do_drive = 1'b1;
        end else if (c_s > tgt_s) begin
            n_rise_p = 1'b0;
            if (!r_sink_p) begin
                if (el >= PHASE_MS) begin
                    do_drive = 1'b1;
                    n_mark   = i_item.now_ms;
                    if (c_s - prev_s <= dlt_s) begin
                        n_sink_p = 1'b1;
                    end
                end else if (el >= HALF_MS) begin
                    do_drive = 1'b1;
                    cmd      = MOT_SINK;
                    n_prev   = i_item.pressure_q4;
                end
            end else if (el <= HALF_MS) begin
                do_drive = 1'b1;
                cmd      = MOT_RISE;
            end else if (el >= {16'd0, i_cfg.hold_ms} && in_band) begin
                n_sink_p = 1'b0;
            end
        end else if (c_s < tgt_s) begin
            n_sink_p = 1'b0;
            if (!r_rise_p) begin
                if (el >= PHASE_MS) begin
                    do_drive = 1'b1;
                    n_mark   = i_item.now_ms;
                    if (prev_s - c_s <= dlt_s) begin
                        n_rise_p = 1'b1;
                    end
                end else if (el >= HALF_MS) begin
                    do_drive = 1'b1;
                    cmd      = MOT_RISE;
                    n_prev   = i_item.pressure_q4;
                end
            end else if (el <= HALF_MS) begin
                do_drive = 1'b1;
                cmd      = MOT_SINK;
            end else if (el >= {16'd0, i_cfg.hold_ms} && in_band) begin
                n_rise_p = 1'b0;
            end
        end
    end

    // Map the command onto the pins; no command keeps the old levels.
    always_comb begin
        n_motion = r_motion;
        n_pin_a  = r_pin_a;
        n_pin_b  = r_pin_b;
        if (do_drive) begin
            n_motion = cmd;
            n_pin_a  = (cmd == MOT_SINK) ? i_cfg.drive_speed : 8'd0;
            n_pin_b  = (cmd == MOT_RISE) ? i_cfg.drive_speed : 8'd0;
        end
    end

    assign o_result.drive_a     = n_pin_a;
    assign o_result.drive_b     = n_pin_b;
    assign o_result.motion      = n_motion;
    assign o_result.auto_active = n_auto;
    assign o_result.calibrated  = n_settled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto    <= 1'b0;
            r_settled <= 1'b0;
            r_sink_p  <= 1'b0;
            r_rise_p  <= 1'b0;
            r_prev    <= RST_PREV;
            r_min     <= RST_MIN;
            r_mark    <= '0;
            r_pin_a   <= '0;
            r_pin_b   <= '0;
            r_motion  <= MOT_STOP;
        end else if (i_step) begin
            r_auto    <= n_auto;
            r_settled <= n_settled;
            r_sink_p  <= n_sink_p;
            r_rise_p  <= n_rise_p;
            r_prev    <= n_prev;
            r_min     <= n_min;
            r_mark    <= n_mark;
            r_pin_a   <= n_pin_a;
            r_pin_b   <= n_pin_b;
            r_motion  <= n_motion;
        end
    end

endmodule

// ===== design/buoyancy_depth_controller.sv =====
// Top level of the buoyancy depth controller: input register, controller
// update, result register and configuration port. Uses bdc_pkg, bdc_regs, bdc_ctrl.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+-------------------------------
//   input    | i_in_valid / o_in_ready      | i_in_item  (t_in_item)
//   result   | o_out_valid / i_out_ready    | o_out_item (t_out_item)
//   config   | psel, penable, pwrite/pready | paddr, pwdata, prdata
//
// One item per cycle sustained while i_out_ready holds; an accepted item
// passes the input register, then the controller update into the result
// register, from which it leaves when i_out_ready is high.
// The state update is a single pass of compares and a 32-bit
// subtract, so consecutive items flow without bubbles.
// Reset is synchronous, active low: control state and registers take their
// defaults, both pipeline stages empty. A stalled result holds the result
// register; the input register still takes one more item behind it.
module buoyancy_depth_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  bdc_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output bdc_pkg::t_out_item            o_out_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bdc_pkg::ADDR_BITS-1:0] paddr,
    input  logic [bdc_pkg::DATA_BITS-1:0] pwdata,
    output logic [bdc_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready
);
    import bdc_pkg::*;

    t_cfg      cfg;
    logic      r_s1_valid, n_s1_valid;
    t_in_item  r_s1_item;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out_item;
    t_out_item step_result;
    logic      s1_advance;
    logic      in_take;

    bdc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bdc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (s1_advance),
        .i_item   (r_s1_item),
        .o_result (step_result)
    );

    // Advance the staged item when the result register is free or draining.
    assign s1_advance  = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || s1_advance;
    assign in_take     = i_in_valid && o_in_ready;
    assign n_s1_valid  = in_take || (r_s1_valid && !s1_advance);
    assign n_out_valid = s1_advance || (r_out_valid && !i_out_ready);

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: load on take or advance, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_item <= i_in_item;
        end
        if (s1_advance) begin
            r_out_item <= step_result;
        end
    end

`ifndef SYNTHESIS
    a_pins_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_item.drive_a != 8'd0 && r_out_item.drive_b != 8'd0))
        else $error("both motor pins driven");

    a_stop_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.motion == MOT_STOP)
            |-> (r_out_item.drive_a == 8'd0 && r_out_item.drive_b == 8'd0))
        else $error("stopped motor with a pin driven");

    a_calib_needs_auto: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.calibrated) |-> r_out_item.auto_active)
        else $error("calibrated without auto mode");

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_valid && r_out_valid && !i_out_ready))
        else $error("input stalled with room in the pipeline");
`endif

endmodule
